[rtl/core/sitda_pkg.sv]
`default_nettype none

package sitda_pkg;

    localparam int VALUE_W   = 32;
    localparam int CAP_W     = 8;
    localparam int MIND_W    = 4;
    localparam int CHAR_W    = 8;
    localparam int S_TDATA_W = 48;
    localparam int NDIG      = 10;
    localparam int BCD_W     = 4 * NDIG;
    localparam int CNT_W     = $clog2(VALUE_W);
    localparam int LEN_W     = 5;

    localparam logic [CHAR_W-1:0] ASCII_ZERO  = 8'h30;
    localparam logic [CHAR_W-1:0] ASCII_MINUS = 8'h2D;
    localparam logic [CHAR_W-1:0] CHAR_NONE   = 8'h00;

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_CONV = 3'b010,
        ST_EMIT = 3'b100
    } t_state;

    typedef struct packed {
        logic              start;
        logic              neg;
        logic [CAP_W-1:0]  cap;
        logic [MIND_W-1:0] minw;
    } t_emit_req;

    typedef struct packed {
        logic busy;
    } t_emit_stat;

endpackage

`default_nettype wire

[rtl/core/signed_int_to_decimal_ascii.sv]
// Channel   Dir  Handshake             Content
// s_axis    in   i_s_tvalid/o_s_tready value, capacity, min_digits
// m_axis    out  o_m_tvalid/i_m_tready char_out, last, ok
//
// An item is accepted, shifted in bit by bit through the binary-to-BCD
// converter and handed over, then sent as one beat per character (1 to 16).
// Output stalls hold the character register and the sequencer; the next
// item is taken once the last beat of the previous one sits in that register.
// Synchronous active-low reset clears the sequencer and the output valid.
`default_nettype none

module signed_int_to_decimal_ascii (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              i_s_tvalid,
    output logic                                   o_s_tready,
    // [31:0] value, [39:32] capacity, [43:40] min_digits, [47:44] zero
    input  wire logic [sitda_pkg::S_TDATA_W-1:0]   i_s_tdata,
    output logic                                   o_m_tvalid,
    input  wire logic                              i_m_tready,
    // [7:0] char_out
    output logic [sitda_pkg::CHAR_W-1:0]           o_m_tdata,
    output logic                                   o_m_tlast,
    // [0] ok
    output logic                                   o_m_tuser
);

    sitda_pkg::t_state     r_state, n_state;
    sitda_pkg::t_emit_req  w_req;
    sitda_pkg::t_emit_stat w_stat;

    logic                              w_acc;
    logic [sitda_pkg::VALUE_W-1:0]     w_raw;
    logic [sitda_pkg::VALUE_W-1:0]     w_mag;
    logic                              w_done;
    logic [sitda_pkg::BCD_W-1:0]       w_bcd;
    logic                              r_neg;
    logic [sitda_pkg::CAP_W-1:0]       r_cap;
    logic [sitda_pkg::MIND_W-1:0]      r_minw;

    assign o_s_tready = (r_state == sitda_pkg::ST_IDLE);
    assign w_acc      = i_s_tvalid && o_s_tready;
    assign w_raw      = i_s_tdata[sitda_pkg::VALUE_W-1:0];
    assign w_mag      = w_raw[sitda_pkg::VALUE_W-1] ? (~w_raw + 1'b1) : w_raw;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            sitda_pkg::ST_IDLE: begin
                if (w_acc) begin
                    n_state = sitda_pkg::ST_CONV;
                end
            end
            sitda_pkg::ST_CONV: begin
                if (w_done) begin
                    n_state = sitda_pkg::ST_EMIT;
                end
            end
            sitda_pkg::ST_EMIT: begin
                if (!w_stat.busy) begin
                    n_state = sitda_pkg::ST_IDLE;
                end
            end
            default: n_state = sitda_pkg::ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= sitda_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
        if (w_acc) begin
            r_neg  <= w_raw[sitda_pkg::VALUE_W-1];
            r_cap  <= i_s_tdata[39:32];
            r_minw <= i_s_tdata[43:40];
        end
    end

    assign w_req.start = w_done && (r_state == sitda_pkg::ST_CONV);
    assign w_req.neg   = r_neg;
    assign w_req.cap   = r_cap;
    assign w_req.minw  = r_minw;

    sitda_dabble u_dabble (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_acc),
        .i_mag   (w_mag),
        .o_done  (w_done),
        .o_bcd   (w_bcd)
    );

    sitda_emit u_emit (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_req    (w_req),
        .i_bcd    (w_bcd),
        .o_stat   (w_stat),
        .i_tready (i_m_tready),
        .o_tvalid (o_m_tvalid),
        .o_char   (o_m_tdata),
        .o_last   (o_m_tlast),
        .o_ok     (o_m_tuser)
    );

    a_idle_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == sitda_pkg::ST_IDLE) |-> !w_stat.busy)
        else $error("sequencer busy while idle");

    a_acc_conv: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_acc |=> (r_state == sitda_pkg::ST_CONV))
        else $error("accepted beat did not start conversion");

    a_fail_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && !o_m_tuser) |-> (o_m_tlast && (o_m_tdata == sitda_pkg::CHAR_NONE)))
        else $error("failure beat malformed");

    a_char_ascii: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && o_m_tuser) |->
            ((o_m_tdata == sitda_pkg::ASCII_MINUS) ||
             ((o_m_tdata >= sitda_pkg::ASCII_ZERO) && (o_m_tdata <= 8'h39))))
        else $error("character outside sign and digits");

endmodule

`default_nettype wire

[rtl/core/sitda_dabble.sv]
`default_nettype none

module sitda_dabble (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_start,
    input  wire logic [sitda_pkg::VALUE_W-1:0]  i_mag,
    output logic                                o_done,
    output logic [sitda_pkg::BCD_W-1:0]         o_bcd
);

    logic [sitda_pkg::VALUE_W-1:0] r_mag, n_mag;
    logic [sitda_pkg::BCD_W-1:0]   r_bcd, n_bcd;
    logic [sitda_pkg::CNT_W-1:0]   r_cnt, n_cnt;
    logic                          r_run, n_run;
    logic                          r_done, n_done;
    logic [sitda_pkg::BCD_W-1:0]   w_adj;

    // add 3 to every digit of five or more, then shift one bit in
    always_comb begin
        for (int i = 0; i < sitda_pkg::NDIG; i++) begin
            if (r_bcd[4*i +: 4] >= 4'd5) begin
                w_adj[4*i +: 4] = r_bcd[4*i +: 4] + 4'd3;
            end else begin
                w_adj[4*i +: 4] = r_bcd[4*i +: 4];
            end
        end
    end

    always_comb begin
        n_mag  = r_mag;
        n_bcd  = r_bcd;
        n_cnt  = r_cnt;
        n_run  = r_run;
        n_done = 1'b0;
        if (i_start) begin
            n_mag = i_mag;
            n_bcd = '0;
            n_cnt = '0;
            n_run = 1'b1;
        end else if (r_run) begin
            n_bcd = {w_adj[sitda_pkg::BCD_W-2:0], r_mag[sitda_pkg::VALUE_W-1]};
            n_mag = {r_mag[sitda_pkg::VALUE_W-2:0], 1'b0};
            n_cnt = r_cnt + 1'b1;
            if (r_cnt == sitda_pkg::CNT_W'(sitda_pkg::VALUE_W - 1)) begin
                n_run  = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run  <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_run  <= n_run;
            r_done <= n_done;
            r_cnt  <= n_cnt;
        end
        r_mag <= n_mag;
        r_bcd <= n_bcd;
    end

    assign o_done = r_done;
    assign o_bcd  = r_bcd;

endmodule

`default_nettype wire

[rtl/core/sitda_emit.sv]
`default_nettype none

module sitda_emit (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire sitda_pkg::t_emit_req          i_req,
    input  wire logic [sitda_pkg::BCD_W-1:0]   i_bcd,
    output sitda_pkg::t_emit_stat              o_stat,
    input  wire logic                          i_tready,
    output logic                               o_tvalid,
    output logic [sitda_pkg::CHAR_W-1:0]       o_char,
    output logic                               o_last,
    output logic                               o_ok
);

    logic [3:0]                  w_nd;
    logic [3:0]                  w_width;
    logic [sitda_pkg::LEN_W-1:0] w_total;
    logic                        w_fail;
    logic                        w_load;

    logic                        r_act, n_act;
    logic                        r_fail, n_fail;
    logic                        r_negp, n_negp;
    logic [3:0]                  r_pad, n_pad;
    logic [3:0]                  r_dig, n_dig;
    logic [sitda_pkg::LEN_W-1:0] r_rem, n_rem;
    logic [3:0]                  w_bcdsel;

    logic                        r_ovalid, n_ovalid;
    logic [sitda_pkg::CHAR_W-1:0] r_char, n_char;
    logic                        r_last, n_last;
    logic                        r_ok, n_ok;
    logic [sitda_pkg::BCD_W-1:0] r_bcd;

    // significant digits, at least one
    always_comb begin
        w_nd = 4'd1;
        for (int i = 1; i < sitda_pkg::NDIG; i++) begin
            if (i_bcd[4*i +: 4] != 4'd0) begin
                w_nd = 4'(i + 1);
            end
        end
        w_width = (i_req.minw > w_nd) ? i_req.minw : w_nd;
        w_total = {1'b0, w_width} + {{(sitda_pkg::LEN_W-1){1'b0}}, i_req.neg};
        w_fail  = {{(sitda_pkg::CAP_W-sitda_pkg::LEN_W){1'b0}}, w_total} > i_req.cap;
    end

    assign w_load   = r_act && (!r_ovalid || i_tready);
    assign w_bcdsel = r_bcd[{r_dig, 2'b00} +: 4];

    always_comb begin
        n_act    = r_act;
        n_fail   = r_fail;
        n_negp   = r_negp;
        n_pad    = r_pad;
        n_dig    = r_dig;
        n_rem    = r_rem;
        n_ovalid = r_ovalid;
        n_char   = r_char;
        n_last   = r_last;
        n_ok     = r_ok;
        if (r_ovalid && i_tready) begin
            n_ovalid = 1'b0;
        end
        if (i_req.start) begin
            n_act  = 1'b1;
            n_fail = w_fail;
            n_negp = i_req.neg;
            n_pad  = w_width - w_nd;
            n_dig  = w_nd - 4'd1;
            n_rem  = w_total;
        end else if (w_load) begin
            n_ovalid = 1'b1;
            if (r_fail) begin
                n_char = sitda_pkg::CHAR_NONE;
                n_last = 1'b1;
                n_ok   = 1'b0;
                n_act  = 1'b0;
            end else begin
                n_ok   = 1'b1;
                n_last = (r_rem == sitda_pkg::LEN_W'(1));
                n_rem  = r_rem - 1'b1;
                if (r_rem == sitda_pkg::LEN_W'(1)) begin
                    n_act = 1'b0;
                end
                if (r_negp) begin
                    n_char = sitda_pkg::ASCII_MINUS;
                    n_negp = 1'b0;
                end else if (r_pad != 4'd0) begin
                    n_char = sitda_pkg::ASCII_ZERO;
                    n_pad  = r_pad - 4'd1;
                end else begin
                    n_char = sitda_pkg::ASCII_ZERO | {4'd0, w_bcdsel};
                    n_dig  = r_dig - 4'd1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_act    <= 1'b0;
            r_ovalid <= 1'b0;
        end else begin
            r_act    <= n_act;
            r_ovalid <= n_ovalid;
        end
        r_fail <= n_fail;
        r_negp <= n_negp;
        r_pad  <= n_pad;
        r_dig  <= n_dig;
        r_rem  <= n_rem;
        r_char <= n_char;
        r_last <= n_last;
        r_ok   <= n_ok;
        if (i_req.start) begin
            r_bcd <= i_bcd;
        end
    end

    assign o_stat.busy = r_act;
    assign o_tvalid    = r_ovalid;
    assign o_char      = r_char;
    assign o_last      = r_last;
    assign o_ok        = r_ok;

endmodule

`default_nettype wire

[tb/signed_int_to_decimal_ascii_test.sv]
`timescale 1ns / 1ps

module signed_int_to_decimal_ascii_test;

    localparam int HOLD_CYCLES = 300;
    localparam int CYCLE_LIMIT = 200000;
    localparam int MAX_TEXT    = 16;

    typedef struct packed {
        logic signed [sitda_pkg::VALUE_W-1:0] value;
        logic [sitda_pkg::CAP_W-1:0]          cap;
        logic [sitda_pkg::MIND_W-1:0]         mind;
    } t_conv_item;

    typedef struct packed {
        logic [sitda_pkg::CHAR_W-1:0] ch;
        logic                         last;
        logic                         ok;
    } t_char_beat;

    logic                            i_clk      = 1'b0;
    logic                            i_rst_n    = 1'b0;
    logic                            i_s_tvalid = 1'b0;
    logic                            o_s_tready;
    logic [sitda_pkg::S_TDATA_W-1:0] i_s_tdata  = '0;
    logic                            o_m_tvalid;
    logic                            i_m_tready = 1'b0;
    logic [sitda_pkg::CHAR_W-1:0]    o_m_tdata;
    logic                            o_m_tlast;
    logic                            o_m_tuser;

    t_conv_item pending_conversions[$];
    t_char_beat awaited_chars[$];
    t_conv_item in_flight;
    t_char_beat want;

    int  send_idle_pct  = 0;
    int  recv_stall_pct = 0;
    bit  pressure_on    = 1'b0;
    int  hold_cycles    = 0;
    int  bad_beats      = 0;
    int  cycles         = 0;

    signed_int_to_decimal_ascii u_top (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),   // [31:0] value, [39:32] capacity, [43:40] min_digits
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),   // [7:0] char_out
        .o_m_tlast  (o_m_tlast),
        .o_m_tuser  (o_m_tuser)    // [0] ok
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    function automatic void predict_text(input t_conv_item it);
        logic              neg;
        logic [31:0]       mag;
        logic [3:0]        digits[10];
        int                nd;
        int                width;
        int                total;
        int                k;
        int                i;
        neg = it.value[sitda_pkg::VALUE_W-1];
        mag = neg ? (~it.value + 32'd1) : it.value;
        for (nd = 0; nd == 0 || (mag != 0 && nd < 10); nd++) begin
            digits[nd] = 4'(mag % 10);
            mag = mag / 10;
        end
        width = (int'(it.mind) > nd) ? int'(it.mind) : nd;
        total = width + (neg ? 1 : 0);
        if (total > int'(it.cap) || total > MAX_TEXT) begin
            awaited_chars.push_back('{ch: sitda_pkg::CHAR_NONE, last: 1'b1, ok: 1'b0});
            return;
        end
        k = 0;
        if (neg) begin
            k++;
            awaited_chars.push_back('{ch: sitda_pkg::ASCII_MINUS, last: k == total, ok: 1'b1});
        end
        for (i = nd; i < width; i++) begin
            k++;
            awaited_chars.push_back('{ch: sitda_pkg::ASCII_ZERO, last: k == total, ok: 1'b1});
        end
        for (i = nd; i > 0; i--) begin
            k++;
            awaited_chars.push_back('{ch: sitda_pkg::ASCII_ZERO +
                                          sitda_pkg::CHAR_W'(digits[i-1]),
                                      last: k == total, ok: 1'b1});
        end
    endfunction

    // source side
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_s_tvalid <= 1'b0;
        end else begin
            if (i_s_tvalid && o_s_tready)
                predict_text(in_flight);
            if (!i_s_tvalid || o_s_tready) begin
                if (pending_conversions.size() != 0 &&
                    $urandom_range(99) >= send_idle_pct) begin
                    in_flight = pending_conversions.pop_front();
                    i_s_tdata <= {4'h0, in_flight.mind, in_flight.cap, in_flight.value};
                    i_s_tvalid <= 1'b1;
                end else begin
                    i_s_tvalid <= 1'b0;
                end
            end
        end
    end

    // long receiver hold-off for the backpressure phase
    always @(posedge i_clk) begin
        if (pressure_on && hold_cycles < HOLD_CYCLES)
            hold_cycles <= hold_cycles + 1;
    end

    // sink side
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_m_tready <= 1'b0;
        end else begin
            if (o_m_tvalid && i_m_tready) begin
                if (awaited_chars.size() == 0) begin
                    $error("unexpected beat: char_out %h last %b ok %b",
                           o_m_tdata, o_m_tlast, o_m_tuser);
                    bad_beats++;
                end else begin
                    want = awaited_chars.pop_front();
                    if (o_m_tdata !== want.ch) begin
                        $error("char_out: expected %h, got %h", want.ch, o_m_tdata);
                        bad_beats++;
                    end
                    if (o_m_tlast !== want.last) begin
                        $error("last: expected %b, got %b", want.last, o_m_tlast);
                        bad_beats++;
                    end
                    if (o_m_tuser !== want.ok) begin
                        $error("ok: expected %b, got %b", want.ok, o_m_tuser);
                        bad_beats++;
                    end
                end
            end
            i_m_tready <= !(pressure_on && hold_cycles < HOLD_CYCLES) &&
                          $urandom_range(99) >= recv_stall_pct;
        end
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("FAIL");
            $finish;
        end
    end

    task automatic add_item(input logic [31:0] value, input int cap, input int mind);
        pending_conversions.push_back('{value: value, cap: sitda_pkg::CAP_W'(cap),
                                        mind: sitda_pkg::MIND_W'(mind)});
    endtask

    task automatic add_random_items(input int n);
        logic signed [31:0] value;
        logic [31:0]        mag;
        int                 mind;
        int                 nd;
        int                 len;
        int                 cap;
        int                 p;
        repeat (n) begin
            case ($urandom_range(3))
                0: value = $urandom();
                1: value = $urandom_range(0, 20);
                2: begin
                    p = 1;
                    repeat ($urandom_range(9)) p = p * 10;
                    value = p + $urandom_range(2) - 1;
                end
                default: value = $urandom() >> $urandom_range(31);
            endcase
            if (value >= 0 && $urandom_range(1))
                value = -value;
            mind = $urandom_range(1) ? $urandom_range(2) : $urandom_range(15);
            mag = value[31] ? -value : value;
            for (nd = 0; nd == 0 || mag != 0; nd++)
                mag = mag / 10;
            len = ((mind > nd) ? mind : nd) + (value[31] ? 1 : 0);
            if ($urandom_range(3) == 0)
                cap = $urandom_range(255);
            else
                cap = len + $urandom_range(2) - 1;
            add_item(value, cap, mind);
        end
    endtask

    task automatic drain();
        @(negedge i_clk);
        while (pending_conversions.size() != 0 || i_s_tvalid || awaited_chars.size() != 0)
            @(negedge i_clk);
    endtask

    task automatic run_phase(input int send_pct, input int recv_pct, input int n);
        send_idle_pct  = send_pct;
        recv_stall_pct = recv_pct;
        add_random_items(n);
        drain();
    endtask

    initial begin
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        add_item(32'd0, 255, 0);
        add_item(32'd0, 15, 15);
        add_item(32'd0, 14, 15);
        add_item(-32'sd1, 16, 15);
        add_item(-32'sd1, 15, 15);
        add_item(32'h7FFF_FFFF, 10, 0);
        add_item(32'h7FFF_FFFF, 9, 0);
        add_item(32'h8000_0000, 11, 0);
        add_item(32'h8000_0000, 10, 0);
        add_item(32'h8000_0000, 255, 15);
        add_item(32'd5, 0, 0);
        add_item(32'd7, 1, 0);
        add_item(-32'sd7, 2, 1);
        add_item(-32'sd7, 1, 0);
        add_item(32'd1000000000, 255, 3);
        add_item(-32'sd999999999, 13, 12);
        add_item(32'h5555_5555, 170, 10);
        add_item(32'hAAAA_AAAA, 85, 5);
        drain();

        run_phase(0, 0, 45);
        run_phase(45, 0, 45);
        run_phase(0, 45, 45);
        run_phase(12, 12, 45);

        // receiver held off while the source keeps offering
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        pressure_on    = 1'b1;
        add_random_items(12);
        drain();
        pressure_on    = 1'b0;

        repeat (100) @(negedge i_clk);
        if (bad_beats == 0 && awaited_chars.size() == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule

[sim.f]
rtl/core/sitda_pkg.sv
rtl/core/sitda_dabble.sv
rtl/core/sitda_emit.sv
rtl/core/signed_int_to_decimal_ascii.sv
tb/signed_int_to_decimal_ascii_test.sv
